[src/fcrc_pkg.sv]
package fcrc_pkg;

   localparam logic [15:0] RPM_FLOOR     = 16'd2000;
   localparam logic [6:0]  FAILSAFE_DEG  = 7'd90;
   localparam logic [15:0] FULL_SPEED    = 16'hFFFF;

   localparam int          DIV_STEPS     = 32;

   // register indexes
   localparam logic [1:0]  REG_POINT_COUNT  = 2'd0;
   localparam logic [1:0]  REG_MIN_RPM      = 2'd1;
   localparam logic [1:0]  REG_RAMP_DOWN_MS = 2'd2;

   localparam logic OP_SAMPLE = 1'b0;
   localparam logic OP_WRITE  = 1'b1;

   // controller to datapath
   typedef struct packed {
      logic load_sample;
      logic write_point;
      logic rd0;
      logic cap_lo0;
      logic rd_next;
      logic no_more;
      logic cmp;
      logic l1_setup;
      logic div_load;
      logic div_step;
      logic apply_tgt;
      logic l2_setup;
      logic out_load;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic fail;
      logic more;
      logic hit;
      logic div_last;
      logic out_free;
   } sts_type;

endpackage

[src/fcrc_ctrl.sv]
module fcrc_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_operation,
   output logic              req_stall,
   input  fcrc_pkg::sts_type sts,
   output fcrc_pkg::cmd_type cmd
);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_CHECK = 4'd1;
   localparam logic [3:0] S_RD0   = 4'd2;
   localparam logic [3:0] S_RD0W  = 4'd3;
   localparam logic [3:0] S_SRCH  = 4'd4;
   localparam logic [3:0] S_SRCHW = 4'd5;
   localparam logic [3:0] S_L1    = 4'd6;
   localparam logic [3:0] S_LD1   = 4'd7;
   localparam logic [3:0] S_DIV1  = 4'd8;
   localparam logic [3:0] S_TGT   = 4'd9;
   localparam logic [3:0] S_L2    = 4'd10;
   localparam logic [3:0] S_LD2   = 4'd11;
   localparam logic [3:0] S_DIV2  = 4'd12;
   localparam logic [3:0] S_OUT   = 4'd13;

   logic [3:0] state_ff, state_in;

   // held off during reset so no word is taken and then lost
   assign req_stall = reset || (state_ff != S_IDLE);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid && !req_stall) begin
               if (req_operation == fcrc_pkg::OP_WRITE) begin
                  cmd.write_point = 1'b1;
               end else begin
                  cmd.load_sample = 1'b1;
                  state_in        = S_CHECK;
               end
            end
         end
         S_CHECK: state_in = sts.fail ? S_OUT : S_RD0;
         S_RD0: begin
            cmd.rd0  = 1'b1;
            state_in = S_RD0W;
         end
         S_RD0W: begin
            cmd.cap_lo0 = 1'b1;
            state_in    = S_SRCH;
         end
         S_SRCH: begin
            if (sts.more) begin
               cmd.rd_next = 1'b1;
               state_in    = S_SRCHW;
            end else begin
               cmd.no_more = 1'b1;
               state_in    = S_L1;
            end
         end
         S_SRCHW: begin
            cmd.cmp  = 1'b1;
            state_in = sts.hit ? S_SRCH : S_L1;
         end
         S_L1: begin
            cmd.l1_setup = 1'b1;
            state_in     = S_LD1;
         end
         S_LD1: begin
            cmd.div_load = 1'b1;
            state_in     = S_DIV1;
         end
         S_DIV1: begin
            cmd.div_step = 1'b1;
            if (sts.div_last) state_in = S_TGT;
         end
         S_TGT: begin
            cmd.apply_tgt = 1'b1;
            state_in      = S_L2;
         end
         S_L2: begin
            cmd.l2_setup = 1'b1;
            state_in     = S_LD2;
         end
         S_LD2: begin
            cmd.div_load = 1'b1;
            state_in     = S_DIV2;
         end
         S_DIV2: begin
            cmd.div_step = 1'b1;
            if (sts.div_last) state_in = S_OUT;
         end
         S_OUT: begin
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[src/fcrc_dp.sv]
module fcrc_dp #(
   parameter int MAX_POINTS = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  fcrc_pkg::cmd_type   cmd,
   output fcrc_pkg::sts_type   sts,
   input  logic [4:0]          cfg_point_count,
   input  logic [15:0]         cfg_min_rpm,
   input  logic [15:0]         cfg_ramp_down_ms,
   input  logic signed [15:0]  req_temperature,
   input  logic                req_sensor_ok,
   input  logic [31:0]         req_time_ms,
   input  logic [3:0]          req_point_index,
   input  logic [6:0]          req_point_temp,
   input  logic [15:0]         req_point_rpm,
   input  logic [15:0]         req_point_ramp_ms,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [15:0]         rsp_fan_speed,
   output logic                rsp_fail_safe
);

   localparam int IDX_W = $clog2(MAX_POINTS);
   localparam int CNT_W = $clog2(MAX_POINTS + 1);
   localparam int WIDE_W = IDX_W + 4;

   // curve point store: temp, rpm, ramp
   logic [38:0] mem [MAX_POINTS];
   logic [38:0] rdata_ff;
   logic [IDX_W-1:0] rd_addr;

   logic signed [15:0] temp_ff;
   logic               fail_ff;
   logic [31:0]        time_ff;
   logic               started_ff;
   logic [15:0]        target_ff, from_ff, last_ff, len_ff;
   logic [31:0]        start_ff;
   logic [IDX_W-1:0]   lo_ff;
   logic [38:0]        lo_data_ff, hi_data_ff;

   logic [31:0] prod_ff;
   logic [15:0] a_ff, divisor_ff;
   logic        neg_ff;
   logic [16:0] rem_ff;
   logic [31:0] quo_ff;
   logic [5:0]  cnt_ff;

   logic        out_valid_ff;
   logic [15:0] out_speed_ff;
   logic        out_fs_ff;

   logic [WIDE_W-1:0] wr_wide;
   logic [CNT_W-1:0]  used_n;
   logic [CNT_W-1:0]  lo_next;
   logic [6:0]        deg;
   logic [15:0]       init_rpm;
   logic [16:0]       lerp_wide;
   logic [15:0]       lerp_res;
   logic [6:0]        lt, ht;
   logic signed [17:0] lt_scaled;
   logic              use_l1;
   logic [14:0]       num, den;
   logic [15:0]       ls, hs, dlt1;
   logic [31:0]       elapsed;
   logic              direct;
   logic [15:0]       dlt2;
   logic [16:0]       shifted;
   logic              ge;

   assign wr_wide = {{IDX_W{1'b0}}, req_point_index};

   always_comb begin
      if (cfg_point_count == 5'd0) used_n = CNT_W'(1);
      else if (32'(cfg_point_count) > MAX_POINTS) used_n = CNT_W'(MAX_POINTS);
      else if (CNT_W >= 5) used_n = CNT_W'(cfg_point_count);
      else used_n = cfg_point_count[CNT_W-1:0];
   end

   assign lo_next = CNT_W'(lo_ff) + CNT_W'(1);
   assign deg     = temp_ff[15] ? 7'd0 : temp_ff[14:8];
   assign init_rpm = (cfg_min_rpm < fcrc_pkg::RPM_FLOOR) ? fcrc_pkg::RPM_FLOOR : cfg_min_rpm;

   // shared lerp: a +/- quotient, rounding toward floor
   always_comb begin
      if (neg_ff) lerp_wide = {1'b0, a_ff} - {1'b0, quo_ff[15:0]} - 17'(rem_ff != 17'd0);
      else        lerp_wide = {1'b0, a_ff} + {1'b0, quo_ff[15:0]};
   end
   assign lerp_res = lerp_wide[15:0];

   // curve interpolation operands
   assign lt = lo_data_ff[38:32];
   assign ht = hi_data_ff[38:32];
   assign ls = lo_data_ff[31:16];
   assign hs = hi_data_ff[31:16];
   assign lt_scaled = {3'b000, lt, 8'd0};
   assign use_l1 = (ht > lt) && (18'(temp_ff) > lt_scaled);
   always_comb begin
      num = 15'(18'(temp_ff) - lt_scaled);
      den = {ht - lt, 8'd0};
      if (num >= den) num = den;
   end
   assign dlt1 = (hs >= ls) ? hs - ls : ls - hs;

   // ramp operands
   assign elapsed = time_ff - start_ff;
   assign direct  = (len_ff == 16'd0) || (elapsed >= {16'd0, len_ff});
   assign dlt2    = (target_ff >= from_ff) ? target_ff - from_ff : from_ff - target_ff;

   // restoring divider step
   assign shifted = {rem_ff[15:0], quo_ff[31]};
   assign ge      = shifted >= {1'b0, divisor_ff};

   always_comb begin
      sts.fail     = fail_ff;
      sts.more     = lo_next < used_n;
      sts.hit      = rdata_ff[38:32] <= deg;
      sts.div_last = cnt_ff == 6'(fcrc_pkg::DIV_STEPS - 1);
      sts.out_free = !out_valid_ff || !rsp_stall;
   end

   always_comb begin
      if (cmd.rd0) rd_addr = '0;
      else         rd_addr = lo_next[IDX_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (cmd.write_point && (32'(wr_wide) < MAX_POINTS)) begin
         mem[wr_wide[IDX_W-1:0]] <= {req_point_temp, req_point_rpm, req_point_ramp_ms};
      end
      if (cmd.rd0 || cmd.rd_next) rdata_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.load_sample) begin
         temp_ff <= req_temperature;
         time_ff <= req_time_ms;
         fail_ff <= !req_sensor_ok ||
                    (!req_temperature[15] && req_temperature[14:8] >= fcrc_pkg::FAILSAFE_DEG);
      end
      if (cmd.cap_lo0) begin
         lo_ff      <= '0;
         lo_data_ff <= rdata_ff;
      end
      if (cmd.no_more) hi_data_ff <= lo_data_ff;
      if (cmd.cmp) begin
         if (sts.hit) begin
            lo_ff      <= lo_next[IDX_W-1:0];
            lo_data_ff <= rdata_ff;
         end else begin
            hi_data_ff <= rdata_ff;
         end
      end
      if (cmd.l1_setup) begin
         if (use_l1) begin
            prod_ff    <= 32'(dlt1) * 32'(num);
            divisor_ff <= {1'b0, den};
            neg_ff     <= hs < ls;
         end else begin
            prod_ff    <= '0;
            divisor_ff <= 16'd1;
            neg_ff     <= 1'b0;
         end
         a_ff <= ls;
      end
      if (cmd.l2_setup) begin
         if (direct) begin
            prod_ff    <= '0;
            divisor_ff <= 16'd1;
            neg_ff     <= 1'b0;
            a_ff       <= target_ff;
         end else begin
            prod_ff    <= 32'(dlt2) * 32'(elapsed[15:0]);
            divisor_ff <= len_ff;
            neg_ff     <= target_ff < from_ff;
            a_ff       <= from_ff;
         end
      end
      if (cmd.div_load) begin
         rem_ff <= '0;
         quo_ff <= prod_ff;
         cnt_ff <= '0;
      end
      if (cmd.div_step) begin
         rem_ff <= ge ? shifted - {1'b0, divisor_ff} : shifted;
         quo_ff <= {quo_ff[30:0], ge};
         cnt_ff <= cnt_ff + 6'd1;
      end
   end

   // ramp state
   always_ff @(posedge clock) begin
      if (reset) begin
         started_ff <= 1'b0;
         target_ff  <= fcrc_pkg::RPM_FLOOR;
         from_ff    <= fcrc_pkg::RPM_FLOOR;
         last_ff    <= fcrc_pkg::RPM_FLOOR;
         start_ff   <= '0;
         len_ff     <= '0;
      end else begin
         if (cmd.load_sample && !started_ff) begin
            started_ff <= 1'b1;
            target_ff  <= init_rpm;
            from_ff    <= init_rpm;
            last_ff    <= init_rpm;
            start_ff   <= '0;
            len_ff     <= cfg_ramp_down_ms;
         end
         if (cmd.apply_tgt && (lerp_res != target_ff)) begin
            target_ff <= lerp_res;
            start_ff  <= time_ff;
            from_ff   <= last_ff;
            len_ff    <= (lerp_res > last_ff) ? hi_data_ff[15:0] : cfg_ramp_down_ms;
         end
         if (cmd.out_load && !fail_ff) last_ff <= lerp_res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         out_speed_ff <= fail_ff ? fcrc_pkg::FULL_SPEED : lerp_res;
         out_fs_ff    <= fail_ff;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_fan_speed = out_speed_ff;
   assign rsp_fail_safe = out_fs_ff;

endmodule

[src/fan_curve_ramp_controller_core.sv]
// fan curve ramp controller: curve points are loaded with write words and take
// no result; each sample word gives one result word. a failed or overheated
// (90 C and up) sample returns full speed with fail_safe set. a normal sample
// walks the curve point by point, a read and then a compare for each, through
// the single read port of the point store, then runs two 32-step serial
// divisions (curve interpolation, then ramp fraction). one sample is worked at
// a time; the next word can be taken as soon as the result sits in the output
// register, even while that result is stalled
module fan_curve_ramp_controller_core #(
   parameter int MAX_POINTS = 16
) (
   input  logic               clock,
   input  logic               reset,
   // input words
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_operation,
   input  logic signed [15:0] req_temperature,
   input  logic               req_sensor_ok,
   input  logic [31:0]        req_time_ms,
   input  logic [3:0]         req_point_index,
   input  logic [6:0]         req_point_temp,
   input  logic [15:0]        req_point_rpm,
   input  logic [15:0]        req_point_ramp_ms,
   // result words
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [15:0]        rsp_fan_speed,
   output logic               rsp_fail_safe,
   // register port
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [3:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);

   fcrc_pkg::cmd_type cmd;
   fcrc_pkg::sts_type sts;

   logic [4:0]  point_count_ff;
   logic [15:0] min_rpm_ff;
   logic [15:0] ramp_down_ff;
   logic        csr_wr;
   logic [1:0]  csr_idx;

   // registers sit on word addresses, low address bits ignored
   assign pready  = 1'b1;
   assign csr_idx = paddr[3:2];
   assign csr_wr  = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         point_count_ff <= 5'd1;
         min_rpm_ff     <= fcrc_pkg::RPM_FLOOR;
         ramp_down_ff   <= '0;
      end else if (csr_wr) begin
         case (csr_idx)
            fcrc_pkg::REG_POINT_COUNT:  point_count_ff <= pwdata[4:0];
            fcrc_pkg::REG_MIN_RPM:      min_rpm_ff     <= pwdata[15:0];
            fcrc_pkg::REG_RAMP_DOWN_MS: ramp_down_ff   <= pwdata[15:0];
            default: ;
         endcase
      end
   end

   // read back
   always_comb begin
      case (csr_idx)
         fcrc_pkg::REG_POINT_COUNT:  prdata = {27'd0, point_count_ff};
         fcrc_pkg::REG_MIN_RPM:      prdata = {16'd0, min_rpm_ff};
         fcrc_pkg::REG_RAMP_DOWN_MS: prdata = {16'd0, ramp_down_ff};
         default:                    prdata = '0;
      endcase
   end

   // sequencer: search, divide, ramp update
   fcrc_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_operation (req_operation),
      .req_stall     (req_stall),
      .sts           (sts),
      .cmd           (cmd)
   );

   // point store, shared divider, ramp state and output register
   fcrc_dp #(
      .MAX_POINTS (MAX_POINTS)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .cfg_point_count   (point_count_ff),
      .cfg_min_rpm       (min_rpm_ff),
      .cfg_ramp_down_ms  (ramp_down_ff),
      .req_temperature   (req_temperature),
      .req_sensor_ok     (req_sensor_ok),
      .req_time_ms       (req_time_ms),
      .req_point_index   (req_point_index),
      .req_point_temp    (req_point_temp),
      .req_point_rpm     (req_point_rpm),
      .req_point_ramp_ms (req_point_ramp_ms),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_fan_speed     (rsp_fan_speed),
      .rsp_fail_safe     (rsp_fail_safe)
   );

endmodule

[src/fcrc_checker.sv]
module fcrc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        req_operation,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [15:0] rsp_fan_speed,
   input logic        rsp_fail_safe
);

   a_fs_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_fail_safe |-> rsp_fan_speed == 16'hFFFF)
      else $error("fail-safe word without full speed");

   a_sample_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && !req_operation |=> req_stall)
      else $error("sample word not held off");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result word right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_fan_speed))
      else $error("stalled result word changed");

endmodule

bind fan_curve_ramp_controller_core fcrc_checker u_fcrc_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_stall     (req_stall),
   .req_operation (req_operation),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_fan_speed (rsp_fan_speed),
   .rsp_fail_safe (rsp_fail_safe)
);

[tb/fan_curve_ramp_controller_core_tb.sv]
module fan_curve_ramp_controller_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NPTS       = 16;
   localparam int QUIET_WAIT = 200;
   localparam int STUCK_MAX  = 4000;   // cycles with no handshake at all before giving up
   localparam int HOLD_LEN   = 500;    // long result hold-off, fills the block up

   // one input word, plus the typed-in answer for the directed rows that have one
   typedef struct {
      logic               op;
      logic signed [15:0] temp;
      logic               ok;
      logic [31:0]        now;
      logic [3:0]         idx;
      logic [6:0]         ptemp;
      logic [15:0]        prpm;
      logic [15:0]        pramp;
      bit                 known;
      logic [15:0]        k_speed;
      logic               k_fs;
   } fan_word_type;

   typedef struct {
      logic [15:0] speed;
      logic        fs;
   } fan_out_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic               req_operation = fcrc_pkg::OP_SAMPLE;
   logic signed [15:0] req_temperature = '0;
   logic               req_sensor_ok = 1'b0;
   logic [31:0]        req_time_ms = '0;
   logic [3:0]         req_point_index = '0;
   logic [6:0]         req_point_temp = '0;
   logic [15:0]        req_point_rpm = '0;
   logic [15:0]        req_point_ramp_ms = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [15:0]        rsp_fan_speed;
   logic               rsp_fail_safe;
   logic               psel = 1'b0;
   logic               penable = 1'b0;
   logic               pwrite = 1'b0;
   logic [3:0]         paddr = '0;
   logic [31:0]        pwdata = '0;
   logic [31:0]        prdata;
   logic               pready;

   fan_curve_ramp_controller_core dut (.*);

   always #5 clock = ~clock;

   // shadow of the registers and of the controller state
   logic [4:0]  sh_count = 5'd1;
   logic [15:0] sh_min   = fcrc_pkg::RPM_FLOOR;
   logic [15:0] sh_down  = '0;
   logic [6:0]  pt_temp [NPTS];
   logic [15:0] pt_rpm  [NPTS];
   logic [15:0] pt_ramp [NPTS];
   logic [15:0] tgt, ramp_from, last_out, ramp_len;
   logic [31:0] ramp_t0 = '0;
   bit          running = 0;

   fan_out_type speed_q [$];          // speeds still owed by the block
   int          send_idle = 0, rcv_idle = 0;
   bit          hold_go = 0;
   int          bad_cnt = 0;
   int          stuck = 0;
   logic [31:0] now_ms;

   // floor of a + (b - a) * num / den, exact
   function automatic logic [15:0] lerp_rpm(logic [15:0] a, logic [15:0] b,
                                            logic [31:0] num, logic [31:0] den);
      longint unsigned v;
      v = longint'(a) * den;
      if (b >= a) v = v + longint'(b - a) * num;
      else        v = v - longint'(a - b) * num;
      return 16'(v / den);
   endfunction

   function automatic fan_out_type predict_speed(logic signed [15:0] t, logic ok,
                                                 logic [31:0] now);
      fan_out_type r;
      int          deg, n, lo, hi;
      logic [31:0] num, den, elapsed;
      logic [15:0] m, newt;
      if (!running) begin
         m = (sh_min < fcrc_pkg::RPM_FLOOR) ? fcrc_pkg::RPM_FLOOR : sh_min;
         tgt = m; ramp_from = m; last_out = m;
         ramp_t0 = '0; ramp_len = sh_down; running = 1;
      end
      if (!ok || t >= $signed(17'(fcrc_pkg::FAILSAFE_DEG) * 256)) begin
         r.speed = fcrc_pkg::FULL_SPEED; r.fs = 1'b1;
         return r;
      end
      deg = (t < 0) ? 0 : int'(t) / 256;
      n = (sh_count == 0) ? 1 : (sh_count > NPTS) ? NPTS : int'(sh_count);
      lo = 0;
      while (lo + 1 < n && int'(pt_temp[lo + 1]) <= deg) lo++;
      hi = (lo + 1 < n) ? lo + 1 : lo;
      // interpolate only on a rising segment and above its low end
      if (pt_temp[hi] > pt_temp[lo] && int'(t) > int'(pt_temp[lo]) * 256) begin
         num = 32'(int'(t) - int'(pt_temp[lo]) * 256);
         den = 32'((int'(pt_temp[hi]) - int'(pt_temp[lo])) * 256);
         if (num >= den) num = den;
         newt = lerp_rpm(pt_rpm[lo], pt_rpm[hi], num, den);
      end else begin
         newt = pt_rpm[lo];
      end
      // a new target restarts the ramp from where the fan is now
      if (newt != tgt) begin
         tgt = newt;
         ramp_t0 = now;
         ramp_from = last_out;
         ramp_len = (newt > last_out) ? pt_ramp[hi] : sh_down;
      end
      elapsed = now - ramp_t0;
      if (ramp_len == 0 || elapsed >= ramp_len) r.speed = tgt;
      else r.speed = lerp_rpm(ramp_from, tgt, elapsed, 32'(ramp_len));
      last_out = r.speed;
      r.fs = 1'b0;
      return r;
   endfunction

   // offer one word and hold it until taken
   task automatic push_word(fan_word_type w);
      fan_out_type p;
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_operation     <= w.op;
      req_temperature   <= w.temp;
      req_sensor_ok     <= w.ok;
      req_time_ms       <= w.now;
      req_point_index   <= w.idx;
      req_point_temp    <= w.ptemp;
      req_point_rpm     <= w.prpm;
      req_point_ramp_ms <= w.pramp;
      req_valid         <= 1'b1;
      do @(posedge clock); while (req_stall);
      if (w.op == fcrc_pkg::OP_WRITE) begin
         pt_temp[w.idx] = w.ptemp;
         pt_rpm[w.idx]  = w.prpm;
         pt_ramp[w.idx] = w.pramp;
      end else begin
         p = predict_speed(w.temp, w.ok, w.now);
         if (w.known) begin
            p.speed = w.k_speed;
            p.fs    = w.k_fs;
         end
         speed_q.push_back(p);
      end
   endtask

   // sender stops until every owed word is back, then lets the block settle
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (speed_q.size() != 0) @(posedge clock);
      repeat (QUIET_WAIT) @(posedge clock);
   endtask

   task automatic csr_write(logic [1:0] idx, logic [31:0] val);
      psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
      paddr <= {idx, 2'b00}; pwdata <= val;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
      case (idx)
         fcrc_pkg::REG_POINT_COUNT:  sh_count = val[4:0];
         fcrc_pkg::REG_MIN_RPM:      sh_min   = val[15:0];
         fcrc_pkg::REG_RAMP_DOWN_MS: sh_down  = val[15:0];
         default: ;
      endcase
   endtask

   function automatic fan_word_type point_word(int idx, int tmp, int rpm, int rmp);
      fan_word_type w;
      w = '{op: fcrc_pkg::OP_WRITE, temp: 16'($urandom), ok: 1'($urandom), now: $urandom,
            idx: 4'(idx), ptemp: 7'(tmp), prpm: 16'(rpm), pramp: 16'(rmp),
            known: 0, k_speed: '0, k_fs: 1'b0};
      return w;
   endfunction

   function automatic fan_word_type sample_word(int tmp, logic ok, logic [31:0] now);
      fan_word_type w;
      w = '{op: fcrc_pkg::OP_SAMPLE, temp: 16'(tmp), ok: ok, now: now,
            idx: 4'($urandom), ptemp: 7'($urandom), prpm: 16'($urandom),
            pramp: 16'($urandom), known: 0, k_speed: '0, k_fs: 1'b0};
      return w;
   endfunction

   // a fresh curve; mostly rising, sometimes flat steps or any order at all
   task automatic load_curve(bit scrambled);
      int base, rmp, sel;
      base = $urandom_range(0, 20);
      for (int i = 0; i < NPTS; i++) begin
         sel = $urandom_range(9);
         rmp = (sel < 2) ? 0 : (sel < 7) ? $urandom_range(1, 300) : $urandom_range(0, 65535);
         push_word(point_word(i, scrambled ? $urandom_range(0, 127) : base,
                              $urandom_range(0, 65535), rmp));
         base = base + $urandom_range(0, 9);
         if (base > 127) base = 127;
      end
   endtask

   task automatic random_word();
      int sel, tmp;
      sel = $urandom_range(99);
      if (sel < 12) begin
         // single point rewrite, any temperature, so the curve may stop rising
         push_word(point_word($urandom_range(0, NPTS - 1), $urandom_range(0, 127),
                              $urandom_range(0, 65535), $urandom_range(0, 400)));
      end else begin
         sel = $urandom_range(99);
         if (sel < 70)      tmp = $urandom_range(0, 95 * 256);
         else if (sel < 85) tmp = $urandom_range(0, 65535);
         else               tmp = -$urandom_range(0, 3000);
         sel = $urandom_range(99);
         if (sel < 80)      now_ms = now_ms + $urandom_range(0, 40);
         else if (sel < 95) now_ms = now_ms + $urandom_range(0, 2000);
         else               now_ms = $urandom;
         push_word(sample_word(tmp, $urandom_range(99) < 92, now_ms));
      end
   endtask

   fan_word_type directed [13] = '{
      '{fcrc_pkg::OP_WRITE,  16'sd0,      1'b0, 32'd0,        4'd0,  7'd30,  16'd2000,
        16'd100, 0, 16'd0, 1'b0},
      // first sample ever is a failed read: full speed, state still loads
      '{fcrc_pkg::OP_SAMPLE, 16'sd0,      1'b0, 32'd0,        4'd0,  7'd0,   16'd0,
        16'd0, 1, fcrc_pkg::FULL_SPEED, 1'b1},
      // exactly 90 C
      '{fcrc_pkg::OP_SAMPLE, 16'sd23040,  1'b1, 32'd1,        4'd15, 7'd127, 16'hFFFF,
        16'hFFFF, 1, fcrc_pkg::FULL_SPEED, 1'b1},
      // single point: target is that point, min rpm raised to the floor
      '{fcrc_pkg::OP_SAMPLE, 16'sd10240,  1'b1, 32'd5,        4'd0,  7'd0,   16'd0,
        16'd0, 1, 16'd2000, 1'b0},
      '{fcrc_pkg::OP_SAMPLE, -16'sd32768, 1'b1, 32'd6,        4'd0,  7'd0,   16'd0,
        16'd0, 1, 16'd2000, 1'b0},
      '{fcrc_pkg::OP_SAMPLE, 16'sd32767,  1'b1, 32'd7,        4'd0,  7'd0,   16'd0,
        16'd0, 1, fcrc_pkg::FULL_SPEED, 1'b1},
      // just under 90 C
      '{fcrc_pkg::OP_SAMPLE, 16'sd23039,  1'b1, 32'd8,        4'd0,  7'd0,   16'd0,
        16'd0, 1, 16'd2000, 1'b0},
      '{fcrc_pkg::OP_SAMPLE, -16'sd1,     1'b0, 32'hFFFF_FFFF, 4'hF, 7'h7F,  16'hFFFF,
        16'hFFFF, 1, fcrc_pkg::FULL_SPEED, 1'b1},
      '{fcrc_pkg::OP_WRITE,  16'sd0,      1'b0, 32'd0,        4'd15, 7'd127, 16'hFFFF,
        16'hFFFF, 0, 16'd0, 1'b0},
      // new target with a long ramp, then time wraps
      '{fcrc_pkg::OP_WRITE,  16'sd0,      1'b0, 32'd0,        4'd0,  7'd0,   16'd40000,
        16'd1000, 0, 16'd0, 1'b0},
      '{fcrc_pkg::OP_SAMPLE, 16'sd5000,   1'b1, 32'hFFFF_FF00, 4'd0, 7'd0,   16'd0,
        16'd0, 0, 16'd0, 1'b0},
      '{fcrc_pkg::OP_SAMPLE, 16'sd5000,   1'b1, 32'h0000_0100, 4'd0, 7'd0,   16'd0,
        16'd0, 0, 16'd0, 1'b0},
      '{fcrc_pkg::OP_SAMPLE, 16'sd5000,   1'b1, 32'h0000_0400, 4'd0, 7'd0,   16'd0,
        16'd0, 0, 16'd0, 1'b0}
   };

   // result side: random stall, one long hold-off, compare in order
   int hold_cnt = 0;
   always @(posedge clock) begin
      fan_out_type e;
      if (hold_go && hold_cnt < HOLD_LEN) begin
         rsp_stall <= 1'b1;
         hold_cnt  <= hold_cnt + 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rcv_idle);
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         if (speed_q.size() == 0) begin
            bad_cnt++;
            if (bad_cnt <= 10)
               $display("unexpected result word speed=%0d fail_safe=%0b",
                        rsp_fan_speed, rsp_fail_safe);
         end else begin
            e = speed_q.pop_front();
            if (rsp_fan_speed !== e.speed || rsp_fail_safe !== e.fs) begin
               bad_cnt++;
               if (bad_cnt <= 10)
                  $display("result mismatch: speed exp %0d got %0d, fail_safe exp %0b got %0b",
                           e.speed, rsp_fan_speed, e.fs, rsp_fail_safe);
            end
         end
      end
   end

   // watchdog on handshakes
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || psel || reset)
         stuck <= 0;
      else
         stuck <= stuck + 1;
      if (stuck >= STUCK_MAX) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      int cnt_pick [5] = '{16, 0, 31, 2, 16};
      int down_pick [3] = '{0, 65535, 150};
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // first sample will see min rpm below the floor and raise it
      csr_write(fcrc_pkg::REG_MIN_RPM, 32'd1500);
      csr_write(fcrc_pkg::REG_RAMP_DOWN_MS, 32'd0);
      foreach (directed[i]) push_word(directed[i]);
      drain();

      // random part: three idling modes, three phases each
      for (int ph = 0; ph < 9; ph++) begin
         send_idle = (ph < 3) ? 32 : (ph < 6) ? 66 : 0;
         rcv_idle  = (ph < 3) ? 66 : (ph < 6) ? 32 : 0;
         // still sent, but only the first sample ever uses min rpm
         csr_write(fcrc_pkg::REG_MIN_RPM, (ph == 8) ? 32'hFFFF : $urandom);
         csr_write(fcrc_pkg::REG_POINT_COUNT,
                   (ph < 5) ? cnt_pick[ph] : $urandom_range(0, 31));
         csr_write(fcrc_pkg::REG_RAMP_DOWN_MS,
                   (ph < 3) ? down_pick[ph] : $urandom_range(0, 400));
         load_curve(ph == 4);
         now_ms = (ph == 2) ? 32'hFFFF_F000 : $urandom;
         // long hold-off on the result side while words keep coming
         if (ph == 1) hold_go = 1;
         repeat (165) random_word();
         drain();
      end

      if (bad_cnt == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
